/* hdl/slm_pkg.sv */
// shared constants and codes for the serpentine led matrix frame sender
`default_nettype none

package slm_pkg;

    localparam int SIDE_DEF = 8;
    localparam int OP_W     = 3;
    localparam int COORD_W  = 4;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int IN_W     = 2 * COORD_W + COLOR_W;

    localparam logic [OP_W-1:0] OP_STORE     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_START     = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

    typedef logic [COLOR_W-1:0] t_color;

endpackage

`default_nettype wire

/* hdl/slm_ram.sv */
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none

module slm_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/serpentine_led_matrix_frame_sender.sv */
// Serpentine LED matrix frame sender. Colours are kept in a SIDE x SIDE store
// addressed by chain position, with one lit flag per position. A store, clear or
// clear-all is done on acceptance and a blank tick goes on to the output step.
// A start send and the tick that emits a colour run a downward scan over the
// lit flags, one position per cycle; a colour tick reads the stored colour
// first. The input is not ready while an item is being worked on;
// a finished pixel waits in the output register, and a tick that makes a pixel
// also waits while the previous pixel there has not been taken.
`default_nettype none

module serpentine_led_matrix_frame_sender
    import slm_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,  // row, col, green_in, red_in, blue_in
    input  wire logic [OP_W-1:0]   s_axis_tuser,  // operation
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [COLOR_W-1:0]     m_axis_tdata,  // green_out, red_out, blue_out
    output logic                   m_axis_tlast,  // frame_end
    output logic [0:0]             m_axis_tuser   // send_done
);

    localparam int CELLS = SIDE * SIDE;
    localparam int PW    = $clog2(CELLS);
    localparam int CW    = PW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CELLS-1:0]  r_lit, n_lit;
    logic [PW-1:0]     r_scan_pos, n_scan_pos;
    logic [PW-1:0]     r_blank, n_blank;
    logic              r_sending, n_sending;
    logic              r_cont, n_cont;
    logic [CW-1:0]     r_cnt, n_cnt;
    t_color            r_res, n_res;
    logic              r_res_last, n_res_last;
    logic              r_res_done, n_res_done;

    logic              r_ovalid, n_ovalid;
    t_color            r_odata, n_odata;
    logic              r_olast, n_olast;
    logic              r_odone, n_odone;

    logic [COORD_W-1:0] w_row, w_col, w_r0, w_c0;
    t_color             w_color;
    logic               w_in_range;
    logic [PW-1:0]      w_wpos;
    logic               w_accept;
    logic               w_we;
    t_color             w_rdata;
    logic [PW-1:0]      w_chk;

    assign w_row   = s_axis_tdata[COORD_W-1:0];
    assign w_col   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_color = s_axis_tdata[IN_W-1:2*COORD_W];
    assign w_r0    = w_row - COORD_W'(1);
    assign w_c0    = w_col - COORD_W'(1);

    assign w_in_range = (w_row != '0) && ({1'b0, w_row} <= (COORD_W+1)'(SIDE)) &&
                        (w_col != '0) && ({1'b0, w_col} <= (COORD_W+1)'(SIDE));

    assign w_wpos = w_r0[0] ? PW'(int'(w_r0) * SIDE + (SIDE - 1 - int'(w_c0)))
                            : PW'(int'(w_r0) * SIDE + int'(w_c0));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_we          = w_accept && !r_sending && (s_axis_tuser == OP_STORE) && w_in_range;
    assign w_chk         = PW'(r_cnt - CW'(1));

    slm_ram #(
        .DATA_W (COLOR_W),
        .DEPTH  (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wpos),
        .i_wdata (w_color),
        .i_raddr (r_scan_pos),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_lit      = r_lit;
        n_scan_pos = r_scan_pos;
        n_blank    = r_blank;
        n_sending  = r_sending;
        n_cont     = r_cont;
        n_cnt      = r_cnt;
        n_res      = r_res;
        n_res_last = r_res_last;
        n_res_done = r_res_done;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_odata    = r_odata;
        n_olast    = r_olast;
        n_odone    = r_odone;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == OP_TICK) begin
                        if (r_sending) begin
                            if (r_blank != '0) begin
                                n_blank    = r_blank - PW'(1);
                                n_res      = '0;
                                n_res_last = 1'b0;
                                n_res_done = 1'b0;
                                n_state    = ST_OUT;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                    end else if (!r_sending) begin
                        unique case (s_axis_tuser)
                            OP_STORE: begin
                                if (w_in_range) begin
                                    n_lit[w_wpos] = (w_color != '0);
                                end
                            end
                            OP_CLEAR: begin
                                if (w_in_range) begin
                                    n_lit[w_wpos] = 1'b0;
                                end
                            end
                            OP_CLEAR_ALL: begin
                                n_lit = '0;
                            end
                            OP_START: begin
                                n_cnt   = CW'(CELLS);
                                n_cont  = 1'b0;
                                n_state = ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_RD: begin
                n_res      = w_rdata;
                n_res_last = 1'b1;
                n_cnt      = {1'b0, r_scan_pos};
                n_cont     = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == '0) begin
                    if (r_cont) begin
                        n_sending  = 1'b0;
                        n_scan_pos = '0;
                        n_blank    = '0;
                        n_res_done = 1'b1;
                        n_state    = ST_OUT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (r_lit[w_chk]) begin
                    n_scan_pos = w_chk;
                    n_blank    = w_chk;
                    n_sending  = 1'b1;
                    n_res_done = 1'b0;
                    n_state    = r_cont ? ST_OUT : ST_IDLE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_olast  = r_res_last;
                    n_odone  = r_res_done;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lit      <= '0;
            r_scan_pos <= '0;
            r_blank    <= '0;
            r_sending  <= 1'b0;
            r_cont     <= 1'b0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_lit      <= n_lit;
            r_scan_pos <= n_scan_pos;
            r_blank    <= n_blank;
            r_sending  <= n_sending;
            r_cont     <= n_cont;
            r_cnt      <= n_cnt;
            r_ovalid   <= n_ovalid;
        end
        r_res      <= n_res;
        r_res_last <= n_res_last;
        r_res_done <= n_res_done;
        r_odata    <= n_odata;
        r_olast    <= n_olast;
        r_odone    <= n_odone;
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tlast    = r_olast;
    assign m_axis_tuser[0] = r_odone;

    a_blank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_blank == '0))
        else $error("blank count left over outside a send");

    a_blank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blank <= r_scan_pos)
        else $error("blank count above scan position");

    a_lit_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> r_lit[r_scan_pos])
        else $error("send aimed at an unlit position");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("send done without frame end");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("output loaded outside the output step");

endmodule

`default_nettype wire
